>>> sv/bounded_double_ended_queue_core_assert.svh
// Assertion macros shared by the deque core modules.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Property checked on every rising edge outside of reset.
`define BDEQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside of reset.
`define BDEQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/bdeq_pkg.sv
// Shared constants and types of the bounded deque core.
`default_nettype none

package bdeq_pkg;

	localparam int unsigned DEPTH_DEF   = 128;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned ACTION_W    = 3;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned COUNT_W     = 8;
	localparam int unsigned OUT_TDATA_W = 112;

	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Controller to datapath.
	typedef struct packed {
		logic exec;   // apply the accepted request
		logic load;   // capture read data into the front or back cache
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_read;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> sv/bdeq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module bdeq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> sv/bdeq_ctrl.sv
// Request sequencing state machine of the deque core.
`default_nettype none
`include "bounded_double_ended_queue_core_assert.svh"

module bdeq_ctrl
	import bdeq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					// a pop that leaves entries refills its cache from the store
					state_d  = stat.need_read ? S_READ : S_RESP;
				end
			end
			S_READ: begin
				cmd.load = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`BDEQ_ASSERT(a_state_onehot, clk, arst_n, $onehot(state_q), "controller state not one-hot")
	`BDEQ_ASSERT_NEVER(a_no_overlap, clk, arst_n, s_tready && m_tvalid,
		"new request taken while a result is pending")

endmodule

`default_nettype wire

>>> sv/bdeq_datapath.sv
// Deque datapath: entry store, head/tail pointers, count and end caches.
`default_nettype none
`include "bounded_double_ended_queue_core_assert.svh"

module bdeq_datapath
	import bdeq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [DATA_W-1:0]   value,
	input  ctrl_cmd_t                  cmd,
	output dp_stat_t                   stat,
	output logic signed [DATA_W-1:0]   popped_value,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_W-1:0]         count,
	output logic                       is_empty,
	output logic signed [DATA_W-1:0]   front_value,
	output logic signed [DATA_W-1:0]   back_value
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         tail_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [DATA_W-1:0] front_q;
	logic signed [DATA_W-1:0] back_q;
	logic signed [DATA_W-1:0] popped_q;
	status_t                  status_q;
	logic                     sel_front_q;

	logic                     is_push;
	logic                     is_pop;
	logic                     at_front;
	logic                     full;
	logic                     empty;
	logic                     push_ok;
	logic                     pop_ok;
	logic [IDX_W-1:0]         head_inc;
	logic [IDX_W-1:0]         head_dec;
	logic [IDX_W-1:0]         tail_inc;
	logic [IDX_W-1:0]         tail_dec;
	logic [IDX_W-1:0]         tail_dec2;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic [DATA_W-1:0]        rd_data;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
		return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
	endfunction

	always_comb begin
		is_push  = 1'b0;
		is_pop   = 1'b0;
		at_front = 1'b0;
		case (action)
			ACT_PUSH_FRONT: begin
				is_push  = 1'b1;
				at_front = 1'b1;
			end
			ACT_PUSH_BACK: begin
				is_push = 1'b1;
			end
			ACT_POP_FRONT: begin
				is_pop   = 1'b1;
				at_front = 1'b1;
			end
			ACT_POP_BACK: begin
				is_pop = 1'b1;
			end
			default: begin
				// query and unused codes change nothing
				is_push = 1'b0;
			end
		endcase
	end

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign push_ok   = is_push && !full;
	assign pop_ok    = is_pop && !empty;
	assign head_inc  = idx_inc(head_q);
	assign head_dec  = idx_dec(head_q);
	assign tail_inc  = idx_inc(tail_q);
	assign tail_dec  = idx_dec(tail_q);
	assign tail_dec2 = idx_dec(tail_dec);

	// tail_q points one past the back entry
	assign wr_en   = cmd.exec && push_ok;
	assign wr_addr = at_front ? head_dec : tail_q;
	assign rd_en   = cmd.exec && pop_ok;
	assign rd_addr = at_front ? head_inc : tail_dec2;

	assign stat.need_read = pop_ok && (count_q != CNT_W'(1));

	bdeq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			if (push_ok) begin
				count_q <= count_q + 1'b1;
				if (at_front) begin
					head_q <= head_dec;
				end else begin
					tail_q <= tail_inc;
				end
			end else if (pop_ok) begin
				count_q <= count_q - 1'b1;
				if (at_front) begin
					head_q <= head_inc;
				end else begin
					tail_q <= tail_dec;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			sel_front_q <= at_front;
			popped_q    <= pop_ok ? (at_front ? front_q : back_q) : '0;
			if (is_push && full) begin
				status_q <= ST_OVERFLOW;
			end else if (is_pop && empty) begin
				status_q <= ST_UNDERFLOW;
			end else begin
				status_q <= ST_OK;
			end
			// a push onto an empty deque sets both ends
			if (push_ok && (at_front || empty)) begin
				front_q <= value;
			end
			if (push_ok && (!at_front || empty)) begin
				back_q <= value;
			end
		end else if (cmd.load) begin
			if (sel_front_q) begin
				front_q <= rd_data;
			end else begin
				back_q <= rd_data;
			end
		end
	end

	assign count_ext    = {{COUNT_W{1'b0}}, count_q};
	assign count        = count_ext[COUNT_W-1:0];
	assign is_empty     = empty;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign front_value  = empty ? '0 : front_q;
	assign back_value   = empty ? '0 : back_q;

	`BDEQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH),
		"entry count exceeds capacity")
	`BDEQ_ASSERT(a_ptr_meet, clk, arst_n, (empty || full) |-> (head_q == tail_q),
		"head and tail disagree on an empty or full deque")

endmodule

`default_nettype wire

>>> sv/bounded_double_ended_queue_core.sv
// Result: valid in the cycle after a request is accepted; a pop that leaves entries first
// passes through S_READ, where one store read refills the front or back cache.
// Flow: a new request is taken only after the last result has been taken, so any output
// stall holds off requests; the registered store read needs the extra S_READ state.
// Reset: arst_n clears head, tail and count at once; the store is not cleared and needs
// no clearing pass, since data read from unwritten entries is never used.
`default_nettype none

module bounded_double_ended_queue_core
	import bdeq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value
	input  logic [ACTION_W-1:0]    s_tuser,   // [2:0] action
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [31:0] popped_value, [33:32] status, [41:34] count, [42] is_empty,
	// [74:43] front_value, [106:75] back_value, [111:107] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int unsigned PAD_W = OUT_TDATA_W - (4 * DATA_W - DATA_W + STATUS_W + COUNT_W + 1);

	ctrl_cmd_t                cmd;
	dp_stat_t                 stat;
	logic signed [DATA_W-1:0] popped_value;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       count;
	logic                     is_empty;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;

	bdeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bdeq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (s_tuser),
		.value        (s_tdata),
		.cmd          (cmd),
		.stat         (stat),
		.popped_value (popped_value),
		.status       (status),
		.count        (count),
		.is_empty     (is_empty),
		.front_value  (front_value),
		.back_value   (back_value)
	);

	assign m_tdata = {{PAD_W{1'b0}}, back_value, front_value, is_empty, count, status,
		popped_value};

endmodule

`default_nettype wire

>>> tb/sv/tb_bounded_double_ended_queue_core.sv
// Self-checking testbench of the bounded deque core: predicted results against the stream output.
`timescale 1ns / 100ps

module tb_bounded_double_ended_queue_core;
	import bdeq_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd4;
	localparam int unsigned         ACT_CODES     = 1 << ACTION_W;
	localparam int unsigned         RANDOM_ITEMS  = 1250;
	localparam int unsigned         STALL_LIMIT   = 4000;
	localparam int unsigned         SETTLE_CYCLES = 10;
	localparam int unsigned         REPORT_MAX    = 10;

	typedef struct {
		logic [DATA_W-1:0]  popped;
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic [DATA_W-1:0]  front;
		logic [DATA_W-1:0]  back;
	} deque_result_t;

	class deque_scoreboard;
		logic [DATA_W-1:0] slots [DEPTH_DEF];
		int unsigned       head;
		int unsigned       fill;
		deque_result_t     awaited_q[$];
		int unsigned       errors;

		function new();
			head   = 0;
			fill   = 0;
			errors = 0;
		endfunction

		function int unsigned occupancy();
			return fill;
		endfunction

		function int unsigned outstanding();
			return awaited_q.size();
		endfunction

		// Apply one accepted request to the mirror and queue the result it must produce.
		function void note_request(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
			deque_result_t r;
			r.popped = '0;
			r.status = ST_OK;
			if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
				if (fill >= DEPTH_DEF) begin
					r.status = ST_OVERFLOW;
				end else if (act == ACT_PUSH_FRONT) begin
					head        = (head + DEPTH_DEF - 1) % DEPTH_DEF;
					slots[head] = val;
					fill++;
				end else begin
					slots[(head + fill) % DEPTH_DEF] = val;
					fill++;
				end
			end else if (act == ACT_POP_FRONT || act == ACT_POP_BACK) begin
				if (fill == 0) begin
					r.status = ST_UNDERFLOW;
				end else if (act == ACT_POP_FRONT) begin
					r.popped = slots[head];
					head     = (head + 1) % DEPTH_DEF;
					fill--;
				end else begin
					r.popped = slots[(head + fill - 1) % DEPTH_DEF];
					fill--;
				end
			end
			r.count    = COUNT_W'(fill);
			r.is_empty = (fill == 0);
			r.front    = (fill == 0) ? '0 : slots[head];
			r.back     = (fill == 0) ? '0 : slots[(head + fill - 1) % DEPTH_DEF];
			awaited_q.insert(awaited_q.size(), r);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
			if (act !== exp) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch on %s: expected %h, got %h", name, exp, act);
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d);
			deque_result_t r;
			if (awaited_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result %h", d);
				return;
			end
			r = awaited_q[0];
			awaited_q.delete(0);
			compare_field("popped_value", r.popped, d[31:0]);
			compare_field("status", DATA_W'(r.status), DATA_W'(d[33:32]));
			compare_field("count", DATA_W'(r.count), DATA_W'(d[41:34]));
			compare_field("is_empty", DATA_W'(r.is_empty), DATA_W'(d[42]));
			compare_field("front_value", r.front, d[74:43]);
			compare_field("back_value", r.back, d[106:75]);
		endfunction

		function void close_out();
			if (awaited_q.size() != 0) begin
				errors += awaited_q.size();
				$display("%0d results never arrived", awaited_q.size());
			end
		endfunction
	endclass

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata  = '0;
	logic [ACTION_W-1:0]    s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	deque_scoreboard sb;
	int unsigned     send_idle_pct  = 0;
	int unsigned     recv_stall_pct = 0;
	int unsigned     quiet_cycles   = 0;

	bounded_double_ended_queue_core #(
		.DEPTH(DEPTH_DEF)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic void set_idling(int unsigned mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic issue_request(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Hold off the sender until every queued result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic random_action(input int unsigned push_pct, output logic [ACTION_W-1:0] act);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			act = ACTION_W'($urandom_range(ACT_CODES - 1, ACT_QUERY));
		else if ($urandom_range(99) < push_pct)
			act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
		else
			act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
	endtask

	// Fill to capacity, push past it, then drain below empty.
	task automatic fill_and_drain(inout int unsigned sent);
		logic [ACTION_W-1:0] act;
		while (sb.occupancy() < DEPTH_DEF) begin
			random_action(100, act);
			issue_request(act, pick_value());
			sent++;
		end
		repeat ($urandom_range(3, 1)) begin
			issue_request($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_value());
			sent++;
		end
		while (sb.occupancy() > 0) begin
			random_action(0, act);
			issue_request(act, $urandom);
			sent++;
		end
		repeat ($urandom_range(3, 1)) begin
			issue_request($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
			sent++;
		end
	endtask

	initial begin
		int unsigned         sent;
		int unsigned         episode;
		int unsigned         push_pct;
		logic [ACTION_W-1:0] act;

		sb = new();
		set_idling(0);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Empty queue: underflow on both ends, queries and unused codes.
		issue_request(ACT_POP_FRONT, 32'hffff_ffff);
		issue_request(ACT_POP_BACK, 32'h0000_0000);
		issue_request(ACT_QUERY, $urandom);
		for (int c = ACT_QUERY + 1; c < ACT_CODES; c++)
			issue_request(ACTION_W'(c), $urandom);
		// Front push from head zero wraps the head to the top slot.
		issue_request(ACT_PUSH_FRONT, 32'h8000_0000);
		issue_request(ACT_PUSH_BACK, 32'h7fff_ffff);
		issue_request(ACT_PUSH_FRONT, 32'hffff_ffff);
		issue_request(ACT_PUSH_BACK, 32'h0000_0000);
		issue_request(ACT_QUERY, $urandom);
		issue_request(ACT_POP_BACK, $urandom);
		issue_request(ACT_POP_FRONT, $urandom);
		issue_request(ACT_POP_FRONT, $urandom);
		issue_request(ACT_POP_BACK, $urandom);
		// Drained: head keeps its position for the next pushes.
		issue_request(ACT_POP_FRONT, $urandom);
		issue_request(ACT_PUSH_BACK, 32'h5555_5555);
		issue_request(ACT_PUSH_BACK, 32'haaaa_aaaa);
		issue_request(ACT_POP_FRONT, $urandom);
		issue_request(ACT_POP_FRONT, $urandom);
		issue_request(ACT_QUERY, $urandom);
		wait_drained();

		sent    = 0;
		episode = 0;
		while (sent < RANDOM_ITEMS) begin
			set_idling(episode);
			if (episode % 5 == 0) begin
				fill_and_drain(sent);
			end else begin
				case ($urandom_range(2))
					0:       push_pct = 25;
					1:       push_pct = 50;
					default: push_pct = 75;
				endcase
				repeat (60) begin
					random_action(push_pct, act);
					issue_request(act, pick_value());
					sent++;
				end
			end
			wait_drained();
			episode++;
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
